### rtl/sha1e_pkg.sv
// SHA-1 hash engine: shared package.
// Holds the sequencer state type, the control word to the round unit and the SHA-1 constants.
// No dependencies.
`default_nettype none

package sha1e_pkg;

  localparam int unsigned NumWords = 5;

  localparam logic [NumWords-1:0][31:0] InitChain = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LenBytePos = 6'd56;
  localparam logic [3:0] LastLenByte = 4'd7;
  localparam logic [2:0] LastWordIdx = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PAD,
    ST_OUT
  } sha1e_state_e;

  typedef struct packed {
    logic       append;
    logic [7:0] data;
    logic       start;
    logic       reinit;
  } sha1e_ctrl_t;

endpackage

`default_nettype wire

### rtl/sha1e_round.sv
// SHA-1 hash engine: block buffer, message schedule and shared round unit.
// Runs one compression round per cycle, then adds the working words into the chain value.
// Depends on sha1e_pkg.
`default_nettype none

module sha1e_round import sha1e_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sha1e_ctrl_t                ctrl_i,
  output logic                       done_o,
  output logic [NumWords-1:0][31:0]  chain_o
);

  logic [511:0]               blk_q;
  logic [NumWords-1:0][31:0]  wk_q;
  logic [NumWords-1:0][31:0]  chain_q;
  logic [6:0]                 rnd_q;
  logic                       run_q;
  logic                       add_q;

  logic [31:0] sched_x;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] a_w, b_w, c_w, d_w, e_w;

  assign a_w = wk_q[0];
  assign b_w = wk_q[1];
  assign c_w = wk_q[2];
  assign d_w = wk_q[3];
  assign e_w = wk_q[4];

  assign sched_x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];

  always_comb begin
    if (rnd_q < 7'd16) begin
      w_new = blk_q[511:480];
    end else begin
      w_new = {sched_x[30:0], sched_x[31]};
    end
    if (rnd_q < 7'd20) begin
      f_val = d_w ^ (b_w & (c_w ^ d_w));
      k_val = RoundK0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_w ^ c_w ^ d_w;
      k_val = RoundK1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_w & c_w) | (d_w & (b_w | c_w));
      k_val = RoundK2;
    end else begin
      f_val = b_w ^ c_w ^ d_w;
      k_val = RoundK3;
    end
    t_val = {a_w[26:0], a_w[31:27]} + f_val + e_w + k_val + w_new;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.append) begin
      blk_q <= {blk_q[503:0], ctrl_i.data};
    end else if (run_q) begin
      blk_q <= {blk_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      wk_q <= chain_q;
    end else if (run_q) begin
      wk_q[4] <= d_w;
      wk_q[3] <= c_w;
      wk_q[2] <= {b_w[1:0], b_w[31:2]};
      wk_q[1] <= a_w;
      wk_q[0] <= t_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= '0;
      run_q   <= 1'b0;
      add_q   <= 1'b0;
      chain_q <= InitChain;
    end else begin
      add_q <= 1'b0;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        if (rnd_q == LastRound) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
          rnd_q <= '0;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
      if (ctrl_i.reinit) begin
        chain_q <= InitChain;
      end else if (add_q) begin
        for (int i = 0; i < NumWords; i++) begin
          chain_q[i] <= chain_q[i] + wk_q[i];
        end
      end
    end
  end

  assign done_o  = add_q;
  assign chain_o = chain_q;

endmodule

`default_nettype wire

### rtl/sha1_hash_engine_unit.sv
// SHA-1 hash engine: top level with the byte/padding sequencer and the digest output register.
// Depends on sha1e_pkg and sha1e_round.
//
// Streaming SHA-1. Each accepted input word may carry one message byte and an end-of-message
// mark. A byte that does not complete a 64-byte block is only appended to the block buffer. A
// byte that completes a block holds the input for 80 rounds through the single shared round unit
// plus the addition into the chain value. On end of message the sequencer appends padding and the
// 64-bit length one byte per cycle between compressions, running one or two more compressions,
// then presents the five digest words, H0 first, one per cycle when the output is not stalled.
// The input is stalled from the cycle after an end-of-message word is accepted until the last
// digest word has entered the output register; it may still wait there while a new message starts.
`default_nettype none

module sha1_hash_engine_unit import sha1e_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  input  logic         byte_present_i,
  input  logic         end_of_message_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  digest_word_o,
  output logic [2:0]   word_index_o,
  output logic         last_word_o
);

  sha1e_state_e state_q, state_d;
  sha1e_state_e ret_q, ret_d;
  logic [5:0]   pos_q, pos_d;
  logic [63:0]  bits_q, bits_d;
  logic         first_q, first_d;
  logic         lenph_q, lenph_d;
  logic [3:0]   lcnt_q, lcnt_d;
  logic [2:0]   ocnt_q, ocnt_d;
  logic         ovalid_q, ovalid_d;
  logic [31:0]  oword_q;
  logic [2:0]   oidx_q;
  logic         olast_q;

  sha1e_ctrl_t               ctrl;
  logic                      core_done;
  logic [NumWords-1:0][31:0] chain;

  logic accept;
  logic pad_len;
  logic wrap;
  logic out_ld;

  sha1e_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .done_o  (core_done),
    .chain_o (chain)
  );

  always_comb begin
    accept  = in_valid_i && (state_q == ST_IDLE);
    pad_len = lenph_q || (pos_q == LenBytePos);
    out_ld  = (state_q == ST_OUT) && (!ovalid_q || !out_stall_i);

    ctrl.append = (accept && byte_present_i) || (state_q == ST_PAD);
    if (state_q == ST_IDLE) begin
      ctrl.data = data_byte_i;
    end else if (first_q) begin
      ctrl.data = PadMark;
    end else if (pad_len) begin
      ctrl.data = bits_q[63:56];
    end else begin
      ctrl.data = 8'h00;
    end
    wrap        = ctrl.append && (pos_q == LastBytePos);
    ctrl.start  = wrap;
    ctrl.reinit = out_ld && (ocnt_q == LastWordIdx);

    state_d = state_q;
    ret_d   = ret_q;
    pos_d   = ctrl.append ? pos_q + 6'd1 : pos_q;
    bits_d  = bits_q;
    first_d = first_q;
    lenph_d = lenph_q;
    lcnt_d  = lcnt_q;
    ocnt_d  = ocnt_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (byte_present_i) begin
            bits_d = bits_q + 64'd8;
          end
          first_d = 1'b1;
          lenph_d = 1'b0;
          lcnt_d  = '0;
          if (wrap) begin
            state_d = ST_HASH;
            ret_d   = end_of_message_i ? ST_PAD : ST_IDLE;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        first_d = 1'b0;
        if (!first_q && pad_len) begin
          lenph_d = 1'b1;
          lcnt_d  = lcnt_q + 4'd1;
          bits_d  = {bits_q[55:0], 8'h00};
        end
        if (wrap) begin
          state_d = ST_HASH;
          ret_d   = (!first_q && pad_len && (lcnt_q == LastLenByte)) ? ST_OUT : ST_PAD;
        end
      end
      ST_HASH: begin
        if (core_done) begin
          state_d = ret_q;
          ocnt_d  = '0;
        end
      end
      ST_OUT: begin
        if (out_ld) begin
          ocnt_d = ocnt_q + 3'd1;
          if (ocnt_q == LastWordIdx) begin
            state_d = ST_IDLE;
            pos_d   = '0;
            bits_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_ld) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      pos_q    <= '0;
      bits_q   <= '0;
      first_q  <= 1'b0;
      lenph_q  <= 1'b0;
      lcnt_q   <= '0;
      ocnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      pos_q    <= pos_d;
      bits_q   <= bits_d;
      first_q  <= first_d;
      lenph_q  <= lenph_d;
      lcnt_q   <= lcnt_d;
      ocnt_q   <= ocnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      oword_q <= chain[ocnt_q];
      oidx_q  <= ocnt_q;
      olast_q <= (ocnt_q == LastWordIdx);
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = ovalid_q;
  assign digest_word_o = oword_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = olast_q;

endmodule

`default_nettype wire
